// File: hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst, prop)

`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// File: hdl/mdn_pkg.sv
package mdn_pkg;

  localparam int PIX_W      = 8;
  localparam int WIN_COUNT  = 9;
  localparam int NUM_PASSES = WIN_COUNT;
  localparam int MID_IDX    = WIN_COUNT / 2;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_COUNT-1:0] win_t;

  typedef struct packed {
    logic en;
    logic valid_in;
  } stage_ctrl_t;

endpackage

// File: hdl/mdn_cell.sv
module mdn_cell
  import mdn_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  pix_t a,
  input  pix_t b,
  output pix_t lo,
  output pix_t hi
);

  always_ff @(posedge clk) begin
    if (en) begin
      if (a > b) begin
        lo <= b;
        hi <= a;
      end else begin
        lo <= a;
        hi <= b;
      end
    end
  end

endmodule

// File: hdl/mdn_stage.sv
module mdn_stage
  import mdn_pkg::*;
#(
  parameter bit ODD_PASS = 1'b0
) (
  input  logic        clk,
  input  logic        rst,
  input  stage_ctrl_t ctrl,
  input  win_t        win_in,
  output win_t        win_out,
  output logic        valid_out
);

  localparam int START  = ODD_PASS ? 1 : 0;
  localparam int NPAIRS = (WIN_COUNT - START) / 2;
  localparam int STOP   = START + 2 * NPAIRS;

  // compare-exchange cells on adjacent lane pairs
  for (genvar p = 0; p < NPAIRS; p++) begin : g_pair
    mdn_cell u_cell (
      .clk (clk),
      .en  (ctrl.en),
      .a   (win_in[START + 2 * p]),
      .b   (win_in[START + 2 * p + 1]),
      .lo  (win_out[START + 2 * p]),
      .hi  (win_out[START + 2 * p + 1])
    );
  end

  // lanes left out of this pass
  for (genvar k = 0; k < WIN_COUNT; k++) begin : g_lane
    if (k < START || k >= STOP) begin : g_pass
      always_ff @(posedge clk) begin
        if (ctrl.en) begin
          win_out[k] <= win_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ctrl.en) begin
      valid_out <= ctrl.valid_in;
    end
  end

endmodule

// File: hdl/median_3x3_window_top.sv
// 3x3 median filter.
// input channel: in_valid / in_stall with nine 8-bit pixels of one window,
// row-major, pix_r1c1 the centre. output channel: out_valid / out_stall with
// median_pixel, the fifth smallest of the nine.
// the window runs through nine compare-exchange stages (odd-even
// transposition sort); each stage is one register row. a request moves
// through the stage rows in order, and out_valid is the valid bit of the last
// stage.
// throughput is one request per cycle while out_stall is low.
// when the receiver stalls, the last stage holds its result steady and
// earlier stages keep moving until they close up behind it; in_stall rises
// only when every stage holds a request. after that one request leaves for
// each cycle out_stall is low.
// reset clears all stage valid bits; nothing is in flight afterwards and
// in_stall is low in the first cycle after reset.
`include "assert_macros.svh"

module median_3x3_window_top
  import mdn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  pix_t pix_r0c0,
  input  pix_t pix_r0c1,
  input  pix_t pix_r0c2,
  input  pix_t pix_r1c0,
  input  pix_t pix_r1c1,
  input  pix_t pix_r1c2,
  input  pix_t pix_r2c0,
  input  pix_t pix_r2c1,
  input  pix_t pix_r2c2,
  output logic out_valid,
  input  logic out_stall,
  output pix_t median_pixel
);

  win_t                    win_in;
  win_t                    stage_win [NUM_PASSES];
  logic [NUM_PASSES-1:0]   stage_valid;
  logic [NUM_PASSES-1:0]   stage_en;
  stage_ctrl_t             stage_ctrl [NUM_PASSES];
  logic                    mid_ordered;

  assign win_in[0] = pix_r0c0;
  assign win_in[1] = pix_r0c1;
  assign win_in[2] = pix_r0c2;
  assign win_in[3] = pix_r1c0;
  assign win_in[4] = pix_r1c1;
  assign win_in[5] = pix_r1c2;
  assign win_in[6] = pix_r2c0;
  assign win_in[7] = pix_r2c1;
  assign win_in[8] = pix_r2c2;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    stage_en[NUM_PASSES-1] = !stage_valid[NUM_PASSES-1] || !out_stall;
    for (int i = NUM_PASSES - 2; i >= 0; i--) begin
      stage_en[i] = !stage_valid[i] || stage_en[i+1];
    end
  end

  for (genvar i = 0; i < NUM_PASSES; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign stage_ctrl[i] = '{en: stage_en[i], valid_in: in_valid};
      mdn_stage #(.ODD_PASS(1'b0)) u_stage (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (stage_ctrl[i]),
        .win_in    (win_in),
        .win_out   (stage_win[i]),
        .valid_out (stage_valid[i])
      );
    end else begin : g_next
      assign stage_ctrl[i] = '{en: stage_en[i], valid_in: stage_valid[i-1]};
      mdn_stage #(.ODD_PASS((i % 2) == 1)) u_stage (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (stage_ctrl[i]),
        .win_in    (stage_win[i-1]),
        .win_out   (stage_win[i]),
        .valid_out (stage_valid[i])
      );
    end
  end

  assign in_stall     = !stage_en[0];
  assign out_valid    = stage_valid[NUM_PASSES-1];
  assign median_pixel = stage_win[NUM_PASSES-1][MID_IDX];

  assign mid_ordered = (stage_win[NUM_PASSES-1][MID_IDX-1] <= median_pixel) &&
                       (median_pixel <= stage_win[NUM_PASSES-1][MID_IDX+1]);

  `ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid && !in_stall)
  `ASSERT_CLK(a_no_stall_when_drained, clk, rst, !out_stall |-> !in_stall)
  `ASSERT_CLK(a_middle_ordered, clk, rst, out_valid |-> mid_ordered)

endmodule

// File: tb/median_3x3_window_top_test.sv
`timescale 1ns / 100ps

module median_3x3_window_top_test;
  import mdn_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_WINDOWS = 850;
  localparam int CALM_TAIL = 150;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  win_t win;
  logic out_valid;
  logic out_stall;
  pix_t median_pixel;

  win_t window_queue[$];
  pix_t median_expect[$];
  int errors = 0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  int in_gap = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  median_3x3_window_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pix_r0c0(win[0]),
    .pix_r0c1(win[1]),
    .pix_r0c2(win[2]),
    .pix_r1c0(win[3]),
    .pix_r1c1(win[4]),
    .pix_r1c2(win[5]),
    .pix_r2c0(win[6]),
    .pix_r2c1(win[7]),
    .pix_r2c2(win[8]),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .median_pixel(median_pixel)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // rank selection: the pixel with at most four strictly below and more than four not above
  function automatic pix_t predict_median(win_t w);
    int below;
    int not_above;
    for (int i = 0; i < WIN_COUNT; i++) begin
      below = 0;
      not_above = 0;
      for (int j = 0; j < WIN_COUNT; j++) begin
        if (w[j] < w[i]) below++;
        if (w[j] <= w[i]) not_above++;
      end
      if (below <= MID_IDX && not_above > MID_IDX) return w[i];
    end
    return '0;
  endfunction

  function automatic win_t random_window();
    win_t w;
    int mode;
    pix_t base;
    mode = $urandom_range(0, 3);
    base = pix_t'($urandom);
    for (int k = 0; k < WIN_COUNT; k++) begin
      case (mode)
        0: w[k] = pix_t'($urandom);
        1: w[k] = pix_t'(base + $urandom_range(0, 3));
        2: w[k] = ($urandom_range(0, 2) == 0) ? base : (($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00);
        default: w[k] = ($urandom_range(0, 1) == 1) ? base : pix_t'($urandom);
      endcase
    end
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap == 0 && window_queue.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 19);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (window_queue.size() > 0) begin
        win <= window_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (window_queue.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin : monitor
    pix_t want;
    in_taken = !rst && in_valid && !in_stall;
    out_taken = !rst && out_valid && !out_stall;
    if (in_taken) median_expect.push_back(predict_median(win));
    if (out_taken) begin
      if (median_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected median %0d", median_pixel));
      end else begin
        want = median_expect.pop_front();
        if (median_pixel !== want) begin
          report_mismatch($sformatf("median got %0d want %0d", median_pixel, want));
        end
      end
    end
    idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    win_t w;
    int n;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    win = '0;

    window_queue.push_back('0);
    window_queue.push_back({WIN_COUNT{8'hFF}});
    window_queue.push_back({WIN_COUNT{8'h80}});
    window_queue.push_back({WIN_COUNT{8'hAA}});
    window_queue.push_back({WIN_COUNT{8'h55}});
    window_queue.push_back({8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0});
    window_queue.push_back({8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8});
    // duplicates split four and five
    window_queue.push_back({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
    window_queue.push_back({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    window_queue.push_back({8'd3, 8'd1, 8'd2, 8'd3, 8'd1, 8'd2, 8'd3, 8'd1, 8'd2});
    window_queue.push_back({8'hFE, 8'h01, 8'h40, 8'h80, 8'h00, 8'hFF, 8'h4D, 8'h0D, 8'hC8});
    // centre extreme against the rest
    window_queue.push_back({8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
    window_queue.push_back({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    // each position in turn holds the median
    for (int k = 0; k < WIN_COUNT; k++) begin
      n = 0;
      for (int j = 0; j < WIN_COUNT; j++) begin
        if (j == k) begin
          w[j] = 8'd100;
        end else begin
          w[j] = (n < MID_IDX) ? 8'h00 : 8'hFF;
          n++;
        end
      end
      window_queue.push_back(w);
    end
    for (int i = 0; i < RANDOM_WINDOWS; i++) window_queue.push_back(random_window());

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (window_queue.size() != 0 || in_valid || median_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
